// ----- src/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition is followed by a property in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// ----- src/rfpc_pkg.sv -----
`default_nettype none
package rfpc_pkg;

    localparam int unsigned CH_W      = 16;
    localparam int unsigned DIV_STEPS = 16;
    // entry stage, divider steps, result stage
    localparam int unsigned LAT       = DIV_STEPS + 2;

    localparam logic [CH_W-1:0] FULL15 = 16'd32768;
    localparam logic [CH_W-1:0] HALF15 = 16'd16384;
    localparam logic [CH_W-1:0] MAX8   = 16'd255;

    typedef enum logic [1:0] {
        MODE_WIDEN    = 2'd0,
        MODE_NARROW   = 2'd1,
        MODE_UNPREMUL = 2'd2,
        MODE_RSVD     = 2'd3
    } t_mode;

    // State of one lane as it travels down the divider steps.
    typedef struct packed {
        logic [CH_W-1:0] rem;
        logic [CH_W-1:0] divisor;
        logic [CH_W-1:0] num_lo;
        logic [CH_W-1:0] quot;
        logic [CH_W-1:0] simple;
        logic            sat;
        logic            use_div;
    } t_div_bus;

    // (v * 255 + 16384) >> 15 for v up to full scale
    function automatic logic [CH_W-1:0] narrow_ch(input logic [CH_W-1:0] v);
        logic [24:0] p;
        p = ({9'd0, v} << 8) - {9'd0, v} + {9'd0, HALF15};
        return {8'd0, p[22:15]};
    endfunction

    // (v * 32768 + 127) / 255 = 128v + (128v + 127) / 255
    function automatic logic [CH_W-1:0] widen_ch(input logic [7:0] v);
        logic [14:0] y;
        logic [15:0] s;
        y = {v, 7'h7f};
        s = {1'b0, y} + {9'd0, y[14:8]} + 16'd1;
        return {1'b0, v, 7'd0} + {8'd0, s[15:8]};
    endfunction

endpackage
`default_nettype wire

// ----- src/rgba_fixed15_pixel_converter.sv -----
// Channel   Dir  Handshake                         Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata: red, green, blue, alpha; tuser: mode
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata: red, green, blue, alpha; tuser: sat
//
// One pixel per clock is accepted while the skid register is free; each pixel passes
// through the entry stage, 16 restoring divider steps, the result stage and the output register.
// The divider pipeline is the long path; all four channel lanes run in step.
// Reset (synchronous, active low) clears the stage valid bits and output flags.
// A stall holds the result in the output register and one more in a skid
// register; only a full skid register pauses the pipeline and drops tready.
`default_nettype none
`include "assert_macros.svh"
module rgba_fixed15_pixel_converter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // red [15:0], green [31:16], blue [47:32], alpha [63:48]
    input  wire  [63:0] i_s_axis_tdata,
    // mode [1:0]
    input  wire  [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // red [15:0], green [31:16], blue [47:32], alpha [63:48]
    output logic [63:0] o_m_axis_tdata,
    // saturated [0]
    output logic [0:0]  o_m_axis_tuser
);
    import rfpc_pkg::*;

    t_mode           w_mode;
    t_mode           w_alpha_mode;
    logic            w_en;
    logic [LAT-1:0]  r_vld;
    logic [CH_W-1:0] w_res [0:3];
    logic [3:0]      w_sat;
    logic [63:0]     w_pix;
    logic            w_pix_sat;

    logic            r_out_v;
    logic            n_out_v;
    logic [63:0]     r_out_d;
    logic [63:0]     n_out_d;
    logic            r_out_s;
    logic            n_out_s;
    logic            r_skid_v;
    logic            n_skid_v;
    logic [63:0]     r_skid_d;
    logic [63:0]     n_skid_d;
    logic            r_skid_s;
    logic            n_skid_s;

    // advance the pipeline whenever the skid register is free
    assign w_en            = !r_skid_v;
    assign o_s_axis_tready = !r_skid_v;

    assign w_mode = t_mode'(i_s_axis_tuser);
    // in un-premultiply mode alpha is narrowed, never divided by itself
    assign w_alpha_mode = (w_mode == MODE_UNPREMUL) ? MODE_NARROW : w_mode;

    for (genvar l = 0; l < 4; l++) begin : g_lane
        rfpc_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_mode  ((l == 3) ? w_alpha_mode : w_mode),
            .i_chan  (i_s_axis_tdata[l*CH_W +: CH_W]),
            .i_alpha (i_s_axis_tdata[3*CH_W +: CH_W]),
            .o_res   (w_res[l]),
            .o_sat   (w_sat[l])
        );
    end

    // merge the lanes into one pixel
    assign w_pix     = {w_res[3], w_res[2], w_res[1], w_res[0]};
    assign w_pix_sat = |w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    always_comb begin
        n_out_v  = r_out_v;
        n_out_d  = r_out_d;
        n_out_s  = r_out_s;
        n_skid_v = r_skid_v;
        n_skid_d = r_skid_d;
        n_skid_s = r_skid_s;
        if (!r_out_v || i_m_axis_tready) begin
            if (r_skid_v) begin
                // drain the skid register first
                n_out_v  = 1'b1;
                n_out_d  = r_skid_d;
                n_out_s  = r_skid_s;
                n_skid_v = 1'b0;
            end else if (w_en && r_vld[LAT-1]) begin
                n_out_v = 1'b1;
                n_out_d = w_pix;
                n_out_s = w_pix_sat;
            end else begin
                n_out_v = 1'b0;
            end
        end else if (w_en && r_vld[LAT-1]) begin
            // output held: park the leaving pixel
            n_skid_v = 1'b1;
            n_skid_d = w_pix;
            n_skid_s = w_pix_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        r_out_d  <= n_out_d;
        r_out_s  <= n_out_s;
        r_skid_d <= n_skid_d;
        r_skid_s <= n_skid_s;
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_d;
    assign o_m_axis_tuser  = r_out_s;

    `ASSERT_ALWAYS(a_skid_needs_out, i_clk, i_rst_n, r_skid_v |-> r_out_v)
    `ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, w_en && r_vld[LAT-1] && r_out_v && !i_m_axis_tready, r_skid_v)
    `ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_v && i_m_axis_tready, !r_skid_v)
    `ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, !r_out_v && !r_skid_v && !r_vld[LAT-1], !r_out_v)

endmodule
`default_nettype wire

// ----- src/rfpc_div_step.sv -----
`default_nettype none
module rfpc_div_step (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  wire rfpc_pkg::t_div_bus i_d,
    output rfpc_pkg::t_div_bus   o_q
);
    import rfpc_pkg::*;

    logic [CH_W:0]   w_trial;
    logic [CH_W:0]   w_diff;
    logic            w_ge;
    t_div_bus        n_q;
    t_div_bus        r_q;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {i_d.rem, i_d.num_lo[CH_W-1]};
        w_diff  = w_trial - {1'b0, i_d.divisor};
        w_ge    = (w_trial >= {1'b0, i_d.divisor});
        n_q         = i_d;
        n_q.rem     = w_ge ? w_diff[CH_W-1:0] : w_trial[CH_W-1:0];
        n_q.num_lo  = {i_d.num_lo[CH_W-2:0], 1'b0};
        n_q.quot    = {i_d.quot[CH_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// ----- src/rfpc_lane.sv -----
`default_nettype none
module rfpc_lane (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire rfpc_pkg::t_mode         i_mode,
    input  wire [rfpc_pkg::CH_W-1:0]     i_chan,
    input  wire [rfpc_pkg::CH_W-1:0]     i_alpha,
    output logic [rfpc_pkg::CH_W-1:0]    o_res,
    output logic                         o_sat
);
    import rfpc_pkg::*;

    logic [CH_W-1:0] w_c15;
    logic [CH_W-1:0] w_a15;
    logic            w_c_over;
    logic [30:0]     w_num;
    t_div_bus        n_entry;
    t_div_bus        r_entry;
    t_div_bus        w_stage [0:DIV_STEPS];
    logic [CH_W-1:0] r_res;
    logic            r_sat;

    always_comb begin
        w_c_over = (i_chan > FULL15);
        w_c15    = w_c_over ? FULL15 : i_chan;
        w_a15    = (i_alpha > FULL15) ? FULL15 : i_alpha;
        // dividend for rounded (c << 15) / a
        w_num    = {w_c15, 15'd0} + {16'd0, w_a15[CH_W-1:1]};
        n_entry          = '0;
        n_entry.rem      = {1'b0, w_num[30:16]};
        n_entry.num_lo   = w_num[15:0];
        n_entry.divisor  = w_a15;
        case (i_mode)
            MODE_WIDEN: begin
                n_entry.sat    = (i_chan > MAX8);
                n_entry.simple = widen_ch((i_chan > MAX8) ? 8'hff : i_chan[7:0]);
            end
            MODE_NARROW: begin
                n_entry.sat    = w_c_over;
                n_entry.simple = narrow_ch(w_c15);
            end
            MODE_UNPREMUL: begin
                if (w_a15 == '0) begin
                    n_entry.sat = w_c_over;
                end else if (w_c15 > w_a15) begin
                    n_entry.sat    = 1'b1;
                    n_entry.simple = MAX8;
                end else begin
                    n_entry.sat     = w_c_over;
                    n_entry.use_div = 1'b1;
                end
            end
            default: begin
                n_entry.sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry <= n_entry;
        end
    end

    assign w_stage[0] = r_entry;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        rfpc_div_step u_step (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_stage[g]),
            .o_q   (w_stage[g+1])
        );
    end

    // narrow the quotient, or pass the early result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= w_stage[DIV_STEPS].use_div ? narrow_ch(w_stage[DIV_STEPS].quot)
                                                : w_stage[DIV_STEPS].simple;
            r_sat <= w_stage[DIV_STEPS].sat;
        end
    end

    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import rfpc_pkg::*;

    // One pixel on the stream buses, red in the lowest bits.
    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } t_rgba;

    // Converted pixel plus the clamp flag.
    typedef struct packed {
        t_rgba pix;
        logic  sat;
    } t_converted;

    localparam int unsigned FULL_SCALE = 32768;
    localparam int unsigned HALF_SCALE = 16384;
    localparam int unsigned BYTE_MAX   = 255;
    localparam int unsigned BYTE_HALF  = 127;
    localparam int unsigned RANDOM_PIXELS = 1400;
    localparam int unsigned CALM_PIXELS   = 250;

    // Holds the converted pixels still owed by the block, oldest first.
    class pixel_scoreboard;
        t_converted pending[$];
        int         errors = 0;

        task report(input string msg);
            errors++;
            // cap the printout; every mismatch still counts
            if (errors <= 100)
                $display("%0t ERROR: %s", $realtime, msg);
        endtask

        function automatic int unsigned clamp_full(input int unsigned v, inout bit sat);
            if (v > FULL_SCALE) begin
                sat = 1'b1;
                return FULL_SCALE;
            end
            return v;
        endfunction

        function automatic int unsigned narrow_to_byte(input int unsigned v);
            return (v * BYTE_MAX + HALF_SCALE) >> 15;
        endfunction

        function automatic t_converted convert_pixel(input t_mode m, input t_rgba p);
            int unsigned ch[4];
            int unsigned res[4];
            int unsigned a;
            int unsigned c;
            bit          sat;
            t_converted  q;
            ch[0] = p.red;
            ch[1] = p.green;
            ch[2] = p.blue;
            ch[3] = p.alpha;
            res   = '{default: 0};
            sat   = 1'b0;
            case (m)
                MODE_WIDEN: begin
                    for (int i = 0; i < 4; i++) begin
                        c = ch[i];
                        if (c > BYTE_MAX) begin
                            c   = BYTE_MAX;
                            sat = 1'b1;
                        end
                        res[i] = (c * FULL_SCALE + BYTE_HALF) / BYTE_MAX;
                    end
                end
                MODE_NARROW: begin
                    for (int i = 0; i < 4; i++)
                        res[i] = narrow_to_byte(clamp_full(ch[i], sat));
                end
                MODE_UNPREMUL: begin
                    a = clamp_full(ch[3], sat);
                    for (int i = 0; i < 3; i++) begin
                        c = clamp_full(ch[i], sat);
                        // zero alpha blanks the color; color above alpha pins to max
                        if (a == 0)
                            res[i] = 0;
                        else if (c > a) begin
                            sat    = 1'b1;
                            res[i] = BYTE_MAX;
                        end else
                            res[i] = narrow_to_byte(((c << 15) + a / 2) / a);
                    end
                    res[3] = narrow_to_byte(a);
                end
                default: ;
            endcase
            q.pix.red   = res[0][15:0];
            q.pix.green = res[1][15:0];
            q.pix.blue  = res[2][15:0];
            q.pix.alpha = res[3][15:0];
            q.sat       = sat;
            return q;
        endfunction

        function void note_pixel(input t_mode m, input t_rgba p);
            pending.push_back(convert_pixel(m, p));
        endfunction

        task check_pixel(input logic [63:0] data, input logic sat);
            t_converted want;
            t_rgba      got;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result data=%h sat=%b", data, sat));
                return;
            end
            want = pending.pop_front();
            got  = t_rgba'(data);
            if (got.red !== want.pix.red)
                report($sformatf("red got %0d want %0d", got.red, want.pix.red));
            if (got.green !== want.pix.green)
                report($sformatf("green got %0d want %0d", got.green, want.pix.green));
            if (got.blue !== want.pix.blue)
                report($sformatf("blue got %0d want %0d", got.blue, want.pix.blue));
            if (got.alpha !== want.pix.alpha)
                report($sformatf("alpha got %0d want %0d", got.alpha, want.pix.alpha));
            if (sat !== want.sat)
                report($sformatf("saturated got %b want %b", sat, want.sat));
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = MODE_WIDEN;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    // Random idling on both sides; cleared for the final stretch.
    bit idle_on = 1'b1;

    pixel_scoreboard sb = new();

    rgba_fixed15_pixel_converter dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // Offer one pixel request after an optional idle gap; return once accepted.
    task send_pixel(input t_mode m, input t_rgba p, input int unsigned gap);
        repeat (gap) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        s_tuser  <= m;
        do @(posedge clk); while (!s_tready);
        sb.note_pixel(m, p);
    endtask

    function automatic t_rgba make_rgba(input int unsigned r, input int unsigned g,
                                        input int unsigned b, input int unsigned a);
        t_rgba p;
        p.red   = r[15:0];
        p.green = g[15:0];
        p.blue  = b[15:0];
        p.alpha = a[15:0];
        return p;
    endfunction

    // Channel value for the given mode: mostly in range, some corners, some wide noise.
    function automatic int unsigned pick_channel(input t_mode m);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return $urandom_range(0, 65535);
        if (m == MODE_WIDEN) begin
            if (roll < 20)
                return (roll & 1) ? BYTE_MAX : 0;
            return $urandom_range(0, BYTE_MAX);
        end
        if (roll < 20) begin
            case (roll % 4)
                0: return 0;
                1: return FULL_SCALE - 1;
                2: return FULL_SCALE;
                default: return FULL_SCALE + 1;
            endcase
        end
        return $urandom_range(0, FULL_SCALE);
    endfunction

    // Random pixel; premultiplied data in un-premultiply mode most of the time.
    task send_random_pixel(input int unsigned gap);
        t_mode       m;
        t_rgba       p;
        int unsigned a;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            m = MODE_RSVD;
        else
            m = t_mode'(roll % 3);
        if (m == MODE_UNPREMUL && $urandom_range(0, 99) < 80) begin
            a = pick_channel(m);
            if (a > FULL_SCALE)
                a = $urandom_range(0, FULL_SCALE);
            if ($urandom_range(0, 9) == 0)
                a = $urandom_range(0, 3);
            p = make_rgba($urandom_range(0, a), $urandom_range(0, a),
                          $urandom_range(0, a), a);
        end else
            p = make_rgba(pick_channel(m), pick_channel(m), pick_channel(m),
                          pick_channel(m));
        send_pixel(m, p, gap);
    endtask

    // Result side: random stall bursts while idling is on.
    initial begin
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Sample accepted results at the rising edge.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tuser[0]);
    end

    initial begin
        int unsigned gap;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed corners: widening extremes and wide input.
        send_pixel(MODE_WIDEN, make_rgba(0, 0, 0, 0), 0);
        send_pixel(MODE_WIDEN, make_rgba(255, 255, 255, 255), 0);
        send_pixel(MODE_WIDEN, make_rgba(1, 127, 128, 254), 0);
        send_pixel(MODE_WIDEN, make_rgba(256, 65535, 255, 0), 0);
        send_pixel(MODE_WIDEN, make_rgba(32768, 255, 256, 65535), 0);
        // Narrowing, including input above full scale.
        send_pixel(MODE_NARROW, make_rgba(0, 0, 0, 0), 0);
        send_pixel(MODE_NARROW, make_rgba(32768, 32768, 32768, 32768), 0);
        send_pixel(MODE_NARROW, make_rgba(32767, 16384, 1, 128), 0);
        send_pixel(MODE_NARROW, make_rgba(32769, 65535, 0, 32768), 0);
        // Un-premultiply: zero alpha, full alpha, small alpha, color above alpha.
        send_pixel(MODE_UNPREMUL, make_rgba(1000, 32768, 0, 0), 0);
        send_pixel(MODE_UNPREMUL, make_rgba(65535, 1, 2, 0), 0);
        send_pixel(MODE_UNPREMUL, make_rgba(32768, 16384, 0, 32768), 0);
        send_pixel(MODE_UNPREMUL, make_rgba(100, 50, 1, 100), 0);
        send_pixel(MODE_UNPREMUL, make_rgba(1001, 32768, 0, 1000), 0);
        send_pixel(MODE_UNPREMUL, make_rgba(32768, 32769, 0, 65535), 0);
        send_pixel(MODE_UNPREMUL, make_rgba(1, 0, 1, 1), 0);
        send_pixel(MODE_UNPREMUL, make_rgba(65535, 65535, 65535, 65535), 0);
        // Reserved mode returns all zeros.
        send_pixel(MODE_RSVD, make_rgba(65535, 65535, 65535, 65535), 0);
        send_pixel(MODE_RSVD, make_rgba(0, 0, 0, 0), 0);

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n == RANDOM_PIXELS - CALM_PIXELS)
                idle_on = 1'b0;
            // Drain the pipeline once mid-run before sending on.
            if (n == RANDOM_PIXELS / 2) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge clk);
            end
            gap = 0;
            if (idle_on && $urandom_range(0, 7) == 0)
                gap = $urandom_range(1, 7);
            send_random_pixel(gap);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (2 * LAT) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
